@@ src/sensor_frame_deframer_sum_check_top_assert.svh @@
// Assertion macros for the sensor frame deframer.
// Included by the top level; the macros expand to nothing under SYNTHESIS.
`ifndef SENSOR_FRAME_DEFRAMER_SUM_CHECK_TOP_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_SUM_CHECK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFD_ASSERT_SAME(lbl, ante, cons, msg)
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/sfd_pkg.sv @@
// Shared types and constants for the sensor frame deframer.
// No dependencies; imported by every module of the block.
package sfd_pkg;

  localparam int PAYLOAD_BYTES_DEF = 48;
  localparam int BYTE_W            = 8;
  localparam int IDX_W             = 6;
  localparam int COUNT_W           = 32;
  localparam int DATA_W            = 32;
  localparam int ADDR_W            = 3;

  // Register index, taken from the word address.
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
  } cfg_t;

  typedef struct packed {
    logic               payload_valid;
    logic [BYTE_W-1:0]  payload_byte;
    logic [IDX_W-1:0]   payload_index;
    logic               frame_end;
    logic               frame_good;
    logic [COUNT_W-1:0] good_frames;
  } res_t;

endpackage

@@ src/sfd_apb_regs.sv @@
// APB-style configuration registers: the two header sync bytes.
// Depends on sfd_pkg.
module sfd_apb_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfd_pkg::ADDR_W-1:0] paddr,
  input  logic [sfd_pkg::DATA_W-1:0] pwdata,
  output logic [sfd_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output sfd_pkg::cfg_t             cfg
);
  import sfd_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_HEADER_FIRST:  cfg.header_first  <= pwdata[BYTE_W-1:0];
        REG_HEADER_SECOND: cfg.header_second <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HEADER_FIRST:  prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg.header_first};
      REG_HEADER_SECOND: prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg.header_second};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ src/sfd_frame_fsm.sv @@
// Frame state machine: header hunt, payload count, running sum and checksum.
// Depends on sfd_pkg; produces the result word for the byte now offered.
module sfd_frame_fsm #(
  parameter int PAYLOAD_BYTES = sfd_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sfd_pkg::cfg_t             cfg,
  input  logic                      step,
  input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
  output sfd_pkg::res_t             res
);
  import sfd_pkg::*;

  localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(PAYLOAD_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LOAD,
    PH_CHECK
  } phase_t;

  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  previous_byte;
  logic [CNT_W-1:0]   payload_count, payload_count_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [COUNT_W-1:0] good_frame_count, good_frame_count_next;
  logic [CNT_W+IDX_W-1:0] index_wide;

  // Only the low bits of the position reach the index field.
  assign index_wide = {{IDX_W{1'b0}}, payload_count};

  always_comb begin
    phase_next            = phase;
    payload_count_next    = payload_count;
    running_sum_next      = running_sum;
    good_frame_count_next = good_frame_count;
    res                   = '0;
    case (phase)
      PH_HUNT: begin
        if (previous_byte == cfg.header_first && rx_byte == cfg.header_second) begin
          payload_count_next = '0;
          running_sum_next   = '0;
          phase_next         = PH_LOAD;
        end
      end
      PH_LOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = index_wide[IDX_W-1:0];
        running_sum_next  = running_sum + rx_byte;
        if (payload_count == LAST) begin
          payload_count_next = '0;
          phase_next         = PH_CHECK;
        end else begin
          payload_count_next = payload_count + 1'b1;
        end
      end
      PH_CHECK: begin
        res.frame_end = 1'b1;
        if (running_sum == rx_byte) begin
          res.frame_good        = 1'b1;
          good_frame_count_next = good_frame_count + 1'b1;
        end
        payload_count_next = '0;
        running_sum_next   = '0;
        phase_next         = PH_HUNT;
      end
      default: begin
        payload_count_next = '0;
        running_sum_next   = '0;
        phase_next         = PH_HUNT;
      end
    endcase
    res.good_frames = good_frame_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      previous_byte    <= '0;
      payload_count    <= '0;
      running_sum      <= '0;
      good_frame_count <= '0;
    end else if (step) begin
      phase            <= phase_next;
      previous_byte    <= rx_byte;
      payload_count    <= payload_count_next;
      running_sum      <= running_sum_next;
      good_frame_count <= good_frame_count_next;
    end
  end

endmodule

@@ src/sfd_result_reg.sv @@
// Result register between the state machine and the output channel.
// Depends on sfd_pkg; a new word may enter in the cycle the old one leaves.
module sfd_result_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  sfd_pkg::res_t res_in,
  input  logic          out_ready,
  output logic          in_ready,
  output logic          out_valid,
  output sfd_pkg::res_t res_out
);
  import sfd_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

@@ src/sensor_frame_deframer_sum_check_top.sv @@
// Sensor frame deframer with additive checksum: top level.
// Depends on sfd_pkg, sfd_apb_regs, sfd_frame_fsm, sfd_result_reg and the assert header.
//
// One received byte is taken per cycle while the result register can take
// it, and its result word appears on the output channel in the next cycle;
// the single combinational state machine step lies between the input and
// the result register. The byte is accepted whenever the result register
// is empty or being read in the same cycle. Header bytes are programmed at byte addresses 0 and 4.
`include "sensor_frame_deframer_sum_check_top_assert.svh"

module sensor_frame_deframer_sum_check_top #(
  parameter int PAYLOAD_BYTES = sfd_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfd_pkg::ADDR_W-1:0]  paddr,
  input  logic [sfd_pkg::DATA_W-1:0]  pwdata,
  output logic [sfd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        rx_valid,
  output logic                        rx_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        payload_valid,
  output logic [sfd_pkg::BYTE_W-1:0]  payload_byte,
  output logic [sfd_pkg::IDX_W-1:0]   payload_index,
  output logic                        frame_end,
  output logic                        frame_good,
  output logic [sfd_pkg::COUNT_W-1:0] good_frames
);
  import sfd_pkg::*;

  cfg_t cfg;
  res_t res_comb;
  res_t res_q;
  logic accept;

  assign accept = rx_valid && rx_ready;

  sfd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfd_frame_fsm #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_fsm (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (accept),
    .rx_byte (rx_byte),
    .res     (res_comb)
  );

  sfd_result_reg u_res (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_in    (res_comb),
    .out_ready (res_ready),
    .in_ready  (rx_ready),
    .out_valid (res_valid),
    .res_out   (res_q)
  );

  assign payload_valid = res_q.payload_valid;
  assign payload_byte  = res_q.payload_byte;
  assign payload_index = res_q.payload_index;
  assign frame_end     = res_q.frame_end;
  assign frame_good    = res_q.frame_good;
  assign good_frames   = res_q.good_frames;

  `SFD_ASSERT_NEXT(a_accept_gives_word, accept, res_valid, "accepted byte produced no word")
  `SFD_ASSERT_SAME(a_good_needs_end, res_valid && frame_good, frame_end, "good frame without frame end")
  `SFD_ASSERT_SAME(a_payload_not_end, res_valid && payload_valid, !frame_end, "payload word marked as frame end")
  `SFD_ASSERT_SAME(a_idle_fields_zero, res_valid && !payload_valid, payload_byte == 0 && payload_index == 0, "non-payload word carries payload data")

endmodule
